// ===== rtl/sbhp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbhp_pkg
// Shared types, constants and lookup functions of the sound-bank header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sbhp_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned FREQ_W  = 17;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned LEN_W   = 30;
    localparam int unsigned CTYPE_W = 7;
    localparam int unsigned CSIZE_W = 24;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHUNK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  record_kind;
        logic [31:0]        entry_index;
        logic [31:0]        headers_bytes;
        logic [31:0]        names_bytes;
        logic [31:0]        data_bytes;
        logic [31:0]        mode_value;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [CHAN_W-1:0]  channel_count;
        logic [31:0]        data_offset;
        logic [LEN_W-1:0]   sample_length;
        logic [CTYPE_W-1:0] chunk_type;
        logic [CSIZE_W-1:0] chunk_size;
    } rec_t;

    // file signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h46;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h42;
            default: b = 8'h35;
        endcase
        return b;
    endfunction

    function automatic logic [FREQ_W-1:0] freq_lookup(input logic [3:0] code);
        logic [FREQ_W-1:0] f;
        case (code)
            4'd0:    f = 17'd4000;
            4'd1:    f = 17'd8000;
            4'd2:    f = 17'd11000;
            4'd3:    f = 17'd12000;
            4'd4:    f = 17'd16000;
            4'd5:    f = 17'd22050;
            4'd6:    f = 17'd24000;
            4'd7:    f = 17'd32000;
            4'd9:    f = 17'd48000;
            4'd10:   f = 17'd96000;
            default: f = 17'd44100;
        endcase
        return f;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_lookup(input logic [1:0] code);
        logic [CHAN_W-1:0] c;
        case (code)
            2'd0:    c = 4'd1;
            2'd1:    c = 4'd2;
            2'd2:    c = 4'd6;
            default: c = 4'd8;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sbhp_core.sv =====
// ----------------------------------------------------------------------------
// sbhp_core
// Parser state and the per-byte next-state / record decode.
// ----------------------------------------------------------------------------
`default_nettype none

module sbhp_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   data_byte,
    input  wire logic         first_byte,
    output logic              rec_valid,
    output sbhp_pkg::rec_t    rec
);
    import sbhp_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_SAMPLE  = 3'd2;
    localparam logic [2:0] PH_CHUNK   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [7:0] POS_SIG_END   = 8'd4;
    localparam logic [7:0] POS_WORDS_END = 8'd28;
    localparam logic [7:0] POS_VERSION   = 8'd7;
    localparam logic [7:0] POS_COUNT     = 8'd11;
    localparam logic [7:0] POS_HEADERS   = 8'd15;
    localparam logic [7:0] POS_NAMES     = 8'd19;
    localparam logic [7:0] POS_DATA      = 8'd23;
    localparam logic [7:0] POS_LAST_OLD  = 8'd63;
    localparam logic [7:0] POS_LAST_NEW  = 8'd59;

    logic [2:0]         phase_reg, phase_next;
    logic [7:0]         pos_reg, pos_next;
    logic [63:0]        shift_reg, shift_next;
    logic               old_reg, old_next;
    logic [31:0]        total_reg, total_next;
    logic [31:0]        count_reg, count_next;
    logic [31:0]        hleft_reg, hleft_next;
    logic [CSIZE_W-1:0] pay_reg, pay_next;
    logic               more_reg, more_next;
    logic [63:0]        saved_reg, saved_next;

    always_comb
    begin
        logic [31:0] w;
        logic [7:0]  last;
        logic [2:0]  p3;
        logic [1:0]  p2;
        logic        chunk_done;

        w          = '0;
        last       = '0;
        p3         = '0;
        p2         = '0;
        chunk_done = 1'b0;
        rec_valid  = 1'b0;
        rec        = '0;

        if (first_byte)
        begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            shift_next = '0;
            old_next   = 1'b0;
            total_next = '0;
            count_next = '0;
            hleft_next = '0;
            pay_next   = '0;
            more_next  = 1'b0;
            saved_next = '0;
        end
        else
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            shift_next = shift_reg;
            old_next   = old_reg;
            total_next = total_reg;
            count_next = count_reg;
            hleft_next = hleft_reg;
            pay_next   = pay_reg;
            more_next  = more_reg;
            saved_next = saved_reg;
        end

        case (phase_next)
            PH_IDLE:
            begin
            end
            PH_HEADER:
            begin
                if (pos_next < POS_SIG_END && data_byte != sig_byte(pos_next[1:0]))
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = KIND_ERROR;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    if (pos_next >= POS_SIG_END && pos_next < POS_WORDS_END)
                    begin
                        if (pos_next[1:0] == 2'd0)
                            shift_next = '0;
                        shift_next[{pos_next[1:0], 3'b000} +: 8] =
                            shift_next[{pos_next[1:0], 3'b000} +: 8] | data_byte;
                        w = shift_next[31:0];
                        case (pos_next)
                            POS_VERSION: old_next = (w == '0);
                            POS_COUNT:   total_next = w;
                            POS_HEADERS: hleft_next = w;
                            POS_NAMES:   saved_next[31:0] = w;
                            POS_DATA:    saved_next[63:32] = w;
                            default:     ;
                        endcase
                    end
                    last = old_next ? POS_LAST_OLD : POS_LAST_NEW;
                    if (pos_next >= last)
                    begin
                        rec_valid         = 1'b1;
                        rec.record_kind   = KIND_HEADER;
                        rec.entry_index   = total_next;
                        rec.headers_bytes = hleft_next;
                        rec.names_bytes   = saved_next[31:0];
                        rec.data_bytes    = saved_next[63:32];
                        rec.mode_value    = shift_next[31:0];
                        count_next        = '0;
                        pos_next          = '0;
                        shift_next        = '0;
                        phase_next        = (total_next == '0) ? PH_IDLE : PH_SAMPLE;
                    end
                    else
                        pos_next = pos_next + 8'd1;
                end
            end
            default:
            begin
                if (hleft_next == '0)
                begin
                    // headers region overrun
                    rec_valid       = 1'b1;
                    rec.record_kind = KIND_ERROR;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    hleft_next = hleft_next - 32'd1;
                    case (phase_next)
                        PH_PAYLOAD:
                        begin
                            pay_next   = pay_next - 24'd1;
                            chunk_done = (pay_next == '0);
                        end
                        PH_SAMPLE:
                        begin
                            p3 = pos_next[2:0];
                            shift_next[{p3, 3'b000} +: 8] =
                                shift_next[{p3, 3'b000} +: 8] | data_byte;
                            if (p3 == 3'd7)
                            begin
                                rec_valid         = 1'b1;
                                rec.record_kind   = KIND_SAMPLE;
                                rec.entry_index   = count_next;
                                rec.frequency_hz  = freq_lookup(shift_next[4:1]);
                                rec.channel_count = chan_lookup(shift_next[6:5]);
                                rec.data_offset   = {shift_next[33:7], 5'b00000};
                                rec.sample_length = shift_next[63:34];
                                more_next         = shift_next[0];
                                chunk_done        = 1'b1;
                            end
                            else
                                pos_next = {5'd0, p3 + 3'd1};
                        end
                        default:
                        begin
                            p2 = pos_next[1:0];
                            shift_next[{p2, 3'b000} +: 8] =
                                shift_next[{p2, 3'b000} +: 8] | data_byte;
                            if (p2 == 2'd3)
                            begin
                                w               = shift_next[31:0];
                                rec_valid       = 1'b1;
                                rec.record_kind = KIND_CHUNK;
                                rec.entry_index = count_next;
                                rec.chunk_type  = w[31:25];
                                rec.chunk_size  = w[24:1];
                                more_next       = w[0];
                                pay_next        = w[24:1];
                                if (w[24:1] != '0)
                                begin
                                    phase_next = PH_PAYLOAD;
                                    pos_next   = '0;
                                    shift_next = '0;
                                end
                                else
                                    chunk_done = 1'b1;
                            end
                            else
                                pos_next = {6'd0, p2 + 2'd1};
                        end
                    endcase

                    // next chunk word, or on to the next sample (idle after the last one)
                    if (chunk_done)
                    begin
                        pos_next   = '0;
                        shift_next = '0;
                        if (more_next)
                            phase_next = PH_CHUNK;
                        else
                        begin
                            count_next = count_next + 32'd1;
                            phase_next = (count_next >= total_next) ? PH_IDLE : PH_SAMPLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            shift_reg <= '0;
            old_reg   <= 1'b0;
            total_reg <= '0;
            count_reg <= '0;
            hleft_reg <= '0;
            pay_reg   <= '0;
            more_reg  <= 1'b0;
            saved_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            old_reg   <= old_next;
            total_reg <= total_next;
            count_reg <= count_next;
            hleft_reg <= hleft_next;
            pay_reg   <= pay_next;
            more_reg  <= more_next;
            saved_reg <= saved_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sound_bank_header_parser.sv =====
// ----------------------------------------------------------------------------
// sound_bank_header_parser
// Byte-stream parser for sound-bank file headers and sample entries.
//
// Input stream: one file byte per request on s_axis; s_axis_tuser marks the
// first byte of a new file and restarts the parser from any state.
// Output stream: one record per parsed unit on m_axis (file header, sample
// entry, meta chunk or format error), kind in m_axis_tuser. Bytes that
// complete no unit produce nothing.
// Path: an accepted byte is held in the input register, decoded, and its
// record is captured in the output register (visible on m_axis after that).
// Throughput: one byte per cycle while records are taken; every byte takes
// one pass through the single decode stage before the record register.
// A held record (m_axis_tready low) still lets one more byte into the input
// register; further bytes wait until the record is taken.
// Reset: parser idle, both registers empty; bytes before a first-byte mark
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_bank_header_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tuser,   // first_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] entry_index, [63:32] headers_bytes, [95:64] names_bytes,
    // [127:96] data_bytes, [159:128] mode_value, [176:160] frequency_hz,
    // [180:177] channel_count, [212:181] data_offset, [242:213] sample_length,
    // [249:243] chunk_type, [273:250] chunk_size, [279:274] zero
    output logic [279:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser    // record_kind
);
    import sbhp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       step;
    logic       rec_valid;
    rec_t       rec;
    logic       out_valid_reg, out_valid_next;
    rec_t       out_rec_reg;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    sbhp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (step)
            out_valid_next = rec_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && rec_valid)
            out_rec_reg <= rec;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.record_kind;
    assign m_axis_tdata  = {6'd0,
                            out_rec_reg.chunk_size,
                            out_rec_reg.chunk_type,
                            out_rec_reg.sample_length,
                            out_rec_reg.data_offset,
                            out_rec_reg.channel_count,
                            out_rec_reg.frequency_hz,
                            out_rec_reg.mode_value,
                            out_rec_reg.data_bytes,
                            out_rec_reg.names_bytes,
                            out_rec_reg.headers_bytes,
                            out_rec_reg.entry_index};

endmodule

`default_nettype wire
